// File: rtl/core/srtf_pkg.sv
// Shared types, codes and the sequencer control store for the SRTF scheduler.
package srtf_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT   = CFG_IDX_W'(1);

  localparam logic [4:0]  ACTIVE_COUNT_RST = 5'd16;
  localparam logic [15:0] TIME_LIMIT_RST   = 16'hFFFF;
  localparam logic [4:0]  DONE_MAX         = 5'd31;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2,
    ACT_NOP  = 2'd3
  } act_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot;
    logic [15:0] arrive_at;
    logic [15:0] run_length;
  } in_t;

  typedef struct packed {
    logic        ran_valid;
    logic [3:0]  ran_slot;
    logic        finished;
    logic [15:0] now;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic [4:0]  done_count;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_LOAD     = 4'd1,
    ST_READ     = 4'd2,
    ST_READ_CAP = 4'd3,
    ST_TICK     = 4'd4,
    ST_SCAN     = 4'd5,
    ST_PICK     = 4'd6,
    ST_UPDATE   = 4'd7,
    ST_FINISH   = 4'd8,
    ST_TICK_END = 4'd9,
    ST_EMIT     = 4'd10
  } step_t;

  typedef enum logic [1:0] {
    ADDR_SLOT = 2'd0,
    ADDR_SCAN = 2'd1,
    ADDR_BEST = 2'd2
  } addr_sel_t;

  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_ALWAYS   = 3'd1,
    J_DISPATCH = 3'd2,
    J_LIMIT    = 3'd3,
    J_SCAN     = 3'd4,
    J_NOTFOUND = 3'd5,
    J_REMNZ    = 3'd6,
    J_EMIT     = 3'd7
  } jcond_t;

  // One control word per sequencer step.
  typedef struct packed {
    addr_sel_t addr_sel;
    logic      idle;
    logic      do_load;
    logic      rd_cap;
    logic      scan_init;
    logic      scan_run;
    logic      upd;
    logic      fin;
    logic      adv;
    logic      emit;
    jcond_t    jc;
    step_t     tgt;
  } ucode_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    logic       accept;
    logic [1:0] action;
    logic       limit_hit;
    logic       scan_done;
    logic       found;
    logic       rem_nz;
    logic       out_free;
  } status_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w          = '0;
    w.addr_sel = ADDR_SLOT;
    w.jc       = J_NEXT;
    w.tgt      = ST_IDLE;
    unique case (s)
      ST_IDLE: begin
        w.idle = 1'b1;
        w.jc   = J_DISPATCH;
      end
      ST_LOAD: begin
        w.do_load = 1'b1;
        w.jc      = J_ALWAYS;
        w.tgt     = ST_EMIT;
      end
      ST_READ: begin
        w.addr_sel = ADDR_SLOT;
      end
      ST_READ_CAP: begin
        w.rd_cap = 1'b1;
        w.jc     = J_ALWAYS;
        w.tgt    = ST_EMIT;
      end
      ST_TICK: begin
        w.scan_init = 1'b1;
        w.jc        = J_LIMIT;
        w.tgt       = ST_EMIT;
      end
      ST_SCAN: begin
        w.addr_sel = ADDR_SCAN;
        w.scan_run = 1'b1;
        w.jc       = J_SCAN;
      end
      ST_PICK: begin
        w.addr_sel = ADDR_BEST;
        w.jc       = J_NOTFOUND;
        w.tgt      = ST_TICK_END;
      end
      ST_UPDATE: begin
        w.addr_sel = ADDR_BEST;
        w.upd      = 1'b1;
        w.jc       = J_REMNZ;
        w.tgt      = ST_TICK_END;
      end
      ST_FINISH: begin
        w.fin = 1'b1;
      end
      ST_TICK_END: begin
        w.adv = 1'b1;
      end
      ST_EMIT: begin
        w.emit = 1'b1;
        w.jc   = J_EMIT;
        w.tgt  = ST_IDLE;
      end
      default: begin
        w.jc  = J_ALWAYS;
        w.tgt = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic step_t dispatch_step(input logic [1:0] action);
    step_t s;
    unique case (action)
      ACT_LOAD: s = ST_LOAD;
      ACT_TICK: s = ST_TICK;
      ACT_READ: s = ST_READ;
      default:  s = ST_EMIT;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/srtf_process_scheduler.sv
// Shortest-remaining-time-first scheduler top level: config registers and core.
//
// Input channel (in_valid / in_stall / in_data): one transaction per action.
// A load writes a slot's arrival and burst, a tick runs the arrived slot with
// the least nonzero remaining time for one time unit, a read returns a slot's
// statistics. Every transaction gives exactly one result on the output
// channel (out_valid / out_stall / out_data).
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 sets
// the active slot count, index 1 the time limit; cfg_ready is always high.
// A tick at or past the time limit runs no slot and leaves the clock alone;
// any other tick scans the first min(active_count, SLOTS) slots and advances
// the clock by one even when no slot is ready. The scan reads one slot a
// cycle from the arrival and remaining-time RAMs and picks the slot to run.
// One transaction is in flight at a time: the block takes the next one in
// the cycle after a result is loaded into the output register; a stalled
// result holds until taken and the next result waits behind it.
// Reset clears the clock, the done count and the loaded flags (slots then
// read as unloaded) and restores active count 16 and time limit 65535.
module srtf_process_scheduler import srtf_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [4:0]  active_count_r, active_count_nxt;
  logic [15:0] time_limit_r, time_limit_nxt;
  ucode_t      cw;
  status_t     st;

  assign cfg_ready = 1'b1;

  always_comb begin
    active_count_nxt = active_count_r;
    time_limit_nxt   = time_limit_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ACTIVE_COUNT) begin
        active_count_nxt = cfg_data[4:0];
      end else if (cfg_index == CFG_TIME_LIMIT) begin
        time_limit_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= ACTIVE_COUNT_RST;
      time_limit_r   <= TIME_LIMIT_RST;
    end else begin
      active_count_r <= active_count_nxt;
      time_limit_r   <= time_limit_nxt;
    end
  end

  srtf_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cw    (cw)
  );

  srtf_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cw           (cw),
    .st           (st),
    .active_count (active_count_r),
    .time_limit   (time_limit_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

// File: rtl/core/srtf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srtf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/srtf_useq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module srtf_useq import srtf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t st,
  output ucode_t  cw
);

  step_t step_r, step_nxt;
  step_t step_inc;

  assign cw       = ucode_rom(step_r);
  assign step_inc = step_t'(step_r + 4'd1);

  always_comb begin
    step_nxt = step_r;
    unique case (cw.jc)
      J_NEXT:     step_nxt = step_inc;
      J_ALWAYS:   step_nxt = cw.tgt;
      J_DISPATCH: step_nxt = st.accept ? dispatch_step(st.action) : ST_IDLE;
      J_LIMIT:    step_nxt = st.limit_hit ? cw.tgt : step_inc;
      J_SCAN:     step_nxt = st.scan_done ? step_inc : step_r;
      J_NOTFOUND: step_nxt = st.found ? step_inc : cw.tgt;
      J_REMNZ:    step_nxt = st.rem_nz ? cw.tgt : step_inc;
      J_EMIT:     step_nxt = st.out_free ? cw.tgt : step_r;
      default:    step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: rtl/core/srtf_dpath.sv
// Scheduler datapath: slot tables, minimum scan, time and statistics update.
module srtf_dpath import srtf_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ucode_t      cw,
  output status_t     st,
  input  logic [4:0]  active_count,
  input  logic [15:0] time_limit,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [3:0]  slot_r, slot_nxt;
  logic [15:0] arv_in_r, arv_in_nxt;
  logic [15:0] len_in_r, len_in_nxt;
  logic [SLOTS-1:0] loaded_r, loaded_nxt;
  logic [15:0] now_r, now_nxt;
  logic [4:0]  done_r, done_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [SW-1:0] pend_idx_r, pend_idx_nxt;
  logic        found_r, found_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic [15:0] best_rem_r, best_rem_nxt;
  logic [15:0] tat_r, tat_nxt;
  logic [15:0] burst_r, burst_nxt;
  logic        res_ran_r, res_ran_nxt;
  logic [3:0]  res_slot_r, res_slot_nxt;
  logic        res_fin_r, res_fin_nxt;
  logic [15:0] res_tat_r, res_tat_nxt;
  logic [15:0] res_wt_r, res_wt_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  logic          accept;
  logic          out_free;
  logic [SW-1:0] slot_idx;
  logic          slot_ok;
  logic          slot_wr;
  logic [CW-1:0] eff_count;
  logic [7:0]    ac_ext;
  logic [SW-1:0] raddr;
  logic [31:0]   arr_rdata;
  logic [15:0]   rem_rdata;
  logic [31:0]   stat_rdata;
  logic [15:0]   rem_eff;
  logic          cand;
  logic [15:0]   wt_calc;
  logic          rem_we, stat_we;
  logic [SW-1:0] rem_waddr, stat_waddr;
  logic [15:0]   rem_wdata;
  logic [31:0]   stat_wdata;

  assign accept   = in_valid && cw.idle;
  assign in_stall = !cw.idle;
  assign out_free = !out_valid_r || !out_stall;
  assign slot_idx = SW'(slot_r);
  assign slot_ok  = (32'(slot_r) < SLOTS);
  assign slot_wr  = cw.do_load && slot_ok;

  // Clamp the active count to the number of slots.
  assign ac_ext    = 8'(active_count);
  assign eff_count = (ac_ext > 8'(SLOTS)) ? CW'(SLOTS) : CW'(ac_ext);

  always_comb begin
    unique case (cw.addr_sel)
      ADDR_SCAN: raddr = scan_idx_r[SW-1:0];
      ADDR_BEST: raddr = best_r;
      default:   raddr = slot_idx;
    endcase
  end

  // Unloaded slots read as zero remaining time.
  assign rem_eff = loaded_r[pend_idx_r] ? rem_rdata : 16'd0;
  assign cand    = (arr_rdata[31:16] <= now_r) && (rem_eff != 16'd0) &&
                   (!found_r || (rem_eff < best_rem_r));
  assign wt_calc = (tat_r >= burst_r) ? (tat_r - burst_r) : 16'd0;

  assign rem_we     = slot_wr || cw.upd;
  assign rem_waddr  = cw.upd ? best_r : slot_idx;
  assign rem_wdata  = cw.upd ? (best_rem_r - 16'd1) : len_in_r;
  assign stat_we    = slot_wr || cw.fin;
  assign stat_waddr = cw.fin ? best_r : slot_idx;
  assign stat_wdata = cw.fin ? {tat_r, wt_calc} : 32'd0;

  srtf_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_arr_ram (
    .clk   (clk),
    .we    (slot_wr),
    .waddr (slot_idx),
    .wdata ({arv_in_r, len_in_r}),
    .raddr (raddr),
    .rdata (arr_rdata)
  );

  srtf_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (raddr),
    .rdata (rem_rdata)
  );

  srtf_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (stat_waddr),
    .wdata (stat_wdata),
    .raddr (raddr),
    .rdata (stat_rdata)
  );

  always_comb begin
    st.accept    = accept;
    st.action    = in_data.action;
    st.limit_hit = (now_r >= time_limit);
    st.scan_done = (scan_idx_r >= eff_count) && !pend_v_r;
    st.found     = found_r;
    st.rem_nz    = (best_rem_r != 16'd1);
    st.out_free  = out_free;
  end

  always_comb begin
    slot_nxt     = slot_r;
    arv_in_nxt   = arv_in_r;
    len_in_nxt   = len_in_r;
    loaded_nxt   = loaded_r;
    now_nxt      = now_r;
    done_nxt     = done_r;
    scan_idx_nxt = scan_idx_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_rem_nxt = best_rem_r;
    tat_nxt      = tat_r;
    burst_nxt    = burst_r;
    res_ran_nxt  = res_ran_r;
    res_slot_nxt = res_slot_r;
    res_fin_nxt  = res_fin_r;
    res_tat_nxt  = res_tat_r;
    res_wt_nxt   = res_wt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      slot_nxt     = in_data.slot;
      arv_in_nxt   = in_data.arrive_at;
      len_in_nxt   = in_data.run_length;
      res_ran_nxt  = 1'b0;
      res_slot_nxt = 4'd0;
      res_fin_nxt  = 1'b0;
      res_tat_nxt  = 16'd0;
      res_wt_nxt   = 16'd0;
    end

    if (slot_wr) begin
      loaded_nxt[slot_idx] = 1'b1;
    end

    if (cw.rd_cap && slot_ok && loaded_r[slot_idx]) begin
      res_tat_nxt = stat_rdata[31:16];
      res_wt_nxt  = stat_rdata[15:0];
      res_fin_nxt = (stat_rdata[31:16] != 16'd0);
    end

    if (cw.scan_init) begin
      scan_idx_nxt = '0;
      pend_v_nxt   = 1'b0;
      found_nxt    = 1'b0;
    end

    // Compare the slot read last cycle while issuing the next read.
    if (cw.scan_run) begin
      if (pend_v_r && cand) begin
        found_nxt    = 1'b1;
        best_nxt     = pend_idx_r;
        best_rem_nxt = rem_eff;
      end
      if (scan_idx_r < eff_count) begin
        pend_v_nxt   = 1'b1;
        pend_idx_nxt = scan_idx_r[SW-1:0];
        scan_idx_nxt = scan_idx_r + CW'(1);
      end else begin
        pend_v_nxt = 1'b0;
      end
    end

    if (cw.upd) begin
      tat_nxt      = now_r + 16'd1 - arr_rdata[31:16];
      burst_nxt    = arr_rdata[15:0];
      res_ran_nxt  = 1'b1;
      res_slot_nxt = 4'(best_r);
    end

    if (cw.fin) begin
      res_fin_nxt = 1'b1;
      res_tat_nxt = tat_r;
      res_wt_nxt  = wt_calc;
      if (done_r != DONE_MAX) begin
        done_nxt = done_r + 5'd1;
      end
    end

    if (cw.adv) begin
      now_nxt = now_r + 16'd1;
    end

    if (cw.emit && out_free) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.ran_valid  = res_ran_r;
      out_data_nxt.ran_slot   = res_slot_r;
      out_data_nxt.finished   = res_fin_r;
      out_data_nxt.now        = now_r;
      out_data_nxt.turnaround = res_tat_r;
      out_data_nxt.waiting    = res_wt_r;
      out_data_nxt.done_count = done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= '0;
      now_r       <= 16'd0;
      done_r      <= 5'd0;
      pend_v_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      loaded_r    <= loaded_nxt;
      now_r       <= now_nxt;
      done_r      <= done_nxt;
      pend_v_r    <= pend_v_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    arv_in_r   <= arv_in_nxt;
    len_in_r   <= len_in_nxt;
    scan_idx_r <= scan_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    best_r     <= best_nxt;
    best_rem_r <= best_rem_nxt;
    tat_r      <= tat_nxt;
    burst_r    <= burst_nxt;
    res_ran_r  <= res_ran_nxt;
    res_slot_r <= res_slot_nxt;
    res_fin_r  <= res_fin_nxt;
    res_tat_r  <= res_tat_nxt;
    res_wt_r   <= res_wt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/sv/tb_srtf_process_scheduler.sv
// Self-checking testbench for the SRTF process scheduler: predicted vs. actual results.
`timescale 1ns / 100ps

module tb_srtf_process_scheduler;
  import srtf_pkg::*;

  localparam int IDLE_GAP    = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  srtf_process_scheduler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Scheduler state as predicted from accepted transactions.
  logic [15:0] p_arrival    [SLOTS_DEF];
  logic [15:0] p_burst      [SLOTS_DEF];
  logic [15:0] p_remaining  [SLOTS_DEF];
  logic [15:0] p_turnaround [SLOTS_DEF];
  logic [15:0] p_waiting    [SLOTS_DEF];
  logic [15:0] p_now;
  logic [4:0]  p_done;
  logic [4:0]  p_active;
  logic [15:0] p_limit;

  out_t pending_reports[$];
  int   fail_count   = 0;
  int   item_count   = 0;
  int   cfg_count    = 0;
  int   ran_count    = 0;
  int   finish_count = 0;
  int   limit_skips  = 0;
  int   burst_left   = 0;
  bit   hold_request = 1'b0;

  function automatic out_t schedule_action(input in_t item);
    out_t rep;
    int   span;
    int   best;
    int   best_rem;
    int   spent;
    int   idle_time;
    bit   found;
    rep = '0;
    item_count++;
    case (act_t'(item.action))
      ACT_LOAD: begin
        p_arrival[item.slot]    = item.arrive_at;
        p_burst[item.slot]      = item.run_length;
        p_remaining[item.slot]  = item.run_length;
        p_turnaround[item.slot] = '0;
        p_waiting[item.slot]    = '0;
      end
      ACT_TICK: begin
        if (p_now < p_limit) begin
          span     = (p_active > SLOTS_DEF) ? SLOTS_DEF : int'(p_active);
          found    = 1'b0;
          best     = 0;
          best_rem = 32'h10000;
          for (int i = 0; i < span; i++) begin
            if (p_arrival[i] <= p_now && p_remaining[i] != 0 && p_remaining[i] < best_rem) begin
              best     = i;
              best_rem = p_remaining[i];
              found    = 1'b1;
            end
          end
          if (found) begin
            ran_count++;
            rep.ran_valid     = 1'b1;
            rep.ran_slot      = 4'(best);
            p_remaining[best] = p_remaining[best] - 16'd1;
            if (p_remaining[best] == 0) begin
              // completion counts at the end of this tick
              spent              = int'(p_now) + 1 - int'(p_arrival[best]);
              idle_time          = (spent >= int'(p_burst[best])) ? spent - p_burst[best] : 0;
              p_turnaround[best] = 16'(spent);
              p_waiting[best]    = 16'(idle_time);
              if (p_done < DONE_MAX) p_done++;
              finish_count++;
              rep.finished   = 1'b1;
              rep.turnaround = p_turnaround[best];
              rep.waiting    = p_waiting[best];
            end
          end
          p_now = p_now + 16'd1;
        end else begin
          limit_skips++;
        end
      end
      ACT_READ: begin
        rep.turnaround = p_turnaround[item.slot];
        rep.waiting    = p_waiting[item.slot];
        rep.finished   = (p_turnaround[item.slot] != 0);
      end
      default: ;
    endcase
    rep.now        = p_now;
    rep.done_count = p_done;
    return rep;
  endfunction

  function automatic in_t make_item(input act_t act, input logic [3:0] slot,
                                    input logic [15:0] arrive, input logic [15:0] len);
    in_t it;
    it.action     = act;
    it.slot       = slot;
    it.arrive_at  = arrive;
    it.run_length = len;
    return it;
  endfunction

  function automatic bit field_differs(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Called at a falling edge; returns at a later falling edge with valid still high.
  task automatic send_item(input in_t item);
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_reports.push_back(schedule_action(item));
    @(negedge clk);
  endtask

  task automatic hold_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic pace_sender(input bit gaps_on);
    if (!gaps_on) return;
    if (burst_left == 0) begin
      hold_input($urandom_range(1, 6));
      burst_left = $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Drain every pending result, then let the core go quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ACTIVE_COUNT: p_active = val[4:0];
      CFG_TIME_LIMIT:   p_limit  = val;
      default: ;
    endcase
    cfg_count++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(make_item(ACT_READ, 4'd0, 16'd0, 16'd0));
    send_item(make_item(ACT_READ, 4'd15, 16'hFFFF, 16'hFFFF));
    send_item(make_item(ACT_NOP, 4'd15, 16'hFFFF, 16'hFFFF));
    send_item(make_item(ACT_TICK, 4'd0, 16'd0, 16'd0));           // nothing loaded
    send_item(make_item(ACT_LOAD, 4'd0, p_now, 16'd3));
    send_item(make_item(ACT_LOAD, 4'd1, p_now, 16'd3));           // tie with slot 0
    send_item(make_item(ACT_LOAD, 4'd3, 16'd0, 16'd0));           // zero burst never runs
    send_item(make_item(ACT_LOAD, 4'd15, 16'd0, 16'hFFFF));
    send_item(make_item(ACT_LOAD, 4'd5, 16'hFFFF, 16'd1));        // never arrives
    repeat (8) send_item(make_item(ACT_TICK, 4'd9, 16'h5A5A, 16'hA5A5));
    send_item(make_item(ACT_READ, 4'd0, 16'd0, 16'd0));
    send_item(make_item(ACT_READ, 4'd1, 16'd0, 16'd0));
    send_item(make_item(ACT_READ, 4'd3, 16'd0, 16'd0));
    send_item(make_item(ACT_READ, 4'd5, 16'd0, 16'd0));
    // short job arriving later preempts the long one
    send_item(make_item(ACT_LOAD, 4'd2, p_now + 16'd2, 16'd1));
    repeat (3) send_item(make_item(ACT_TICK, 4'd0, 16'd0, 16'd0));
    send_item(make_item(ACT_READ, 4'd2, 16'd0, 16'd0));
    hold_input(1);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    write_reg(CFG_ACTIVE_COUNT, 16'd0);     // no slot takes part
    send_item(make_item(ACT_LOAD, 4'd0, p_now, 16'd2));
    repeat (3) send_item(make_item(ACT_TICK, 4'd0, 16'd0, 16'd0));
    wait_idle();
    write_reg(CFG_ACTIVE_COUNT, 16'd31);    // clamps to all slots
    send_item(make_item(ACT_LOAD, 4'd15, p_now, 16'd1));
    repeat (3) send_item(make_item(ACT_TICK, 4'd0, 16'd0, 16'd0));
    wait_idle();
    write_reg(CFG_ACTIVE_COUNT, 16'd1);
    repeat (3) send_item(make_item(ACT_TICK, 4'd0, 16'd0, 16'd0));
    wait_idle();
    write_reg(CFG_TIME_LIMIT, 16'd0);       // every tick ignored
    repeat (3) send_item(make_item(ACT_TICK, 4'd0, 16'd0, 16'd0));
    send_item(make_item(ACT_READ, 4'd0, 16'd0, 16'd0));
    wait_idle();
    write_reg(CFG_TIME_LIMIT, p_now + 16'd2);
    write_reg(CFG_ACTIVE_COUNT, 16'd16);
    repeat (5) send_item(make_item(ACT_TICK, 4'd0, 16'd0, 16'd0));
    wait_idle();
    write_reg(CFG_TIME_LIMIT, TIME_LIMIT_RST);
  endtask

  // Hold the output for a long stretch while the sender keeps offering.
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    for (int n = 0; n < 40; n++) begin
      if (n % 4 == 0)
        send_item(make_item(ACT_LOAD, 4'($urandom_range(15)), p_now, 16'($urandom_range(1, 4))));
      else
        send_item(make_item(ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom)));
    end
    hold_input(1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    in_t it;
    int  roll;
    int  span;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0:       write_reg(CFG_ACTIVE_COUNT, 16'd16);
        3:       write_reg(CFG_ACTIVE_COUNT, 16'd1);
        default: write_reg(CFG_ACTIVE_COUNT, 16'($urandom_range(2, 16)));
      endcase
      if (ph == 5) write_reg(CFG_TIME_LIMIT, p_now + 16'd60);
      if (ph == 6) write_reg(CFG_TIME_LIMIT, TIME_LIMIT_RST);
      span = (p_active == 0 || p_active > SLOTS_DEF) ? SLOTS_DEF : int'(p_active);
      for (int n = 0; n < 200; n++) begin
        roll = $urandom_range(99);
        it   = make_item(ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
        if (roll >= 55 && roll < 75) begin
          // well-formed job: arrives soon, mostly short
          it.action     = ACT_LOAD;
          it.slot       = 4'($urandom_range(span - 1));
          it.arrive_at  = p_now + 16'($urandom_range(6));
          it.run_length = ($urandom_range(9) == 0) ? 16'($urandom_range(1, 40))
                                                   : 16'($urandom_range(1, 6));
        end else if (roll >= 75 && roll < 79) begin
          it.action = ACT_LOAD;
        end else if (roll >= 79 && roll < 96) begin
          it.action = ACT_READ;
        end else if (roll >= 96) begin
          it.action = ACT_NOP;
        end
        send_item(it);
        pace_sender(ph != 2);
      end
    end
    hold_input(1);
  endtask

  // Receiver: random stall duty per segment, plus a long hold on request.
  initial begin : receiver
    int seg_left;
    int duty;
    seg_left  = 0;
    duty      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          case ($urandom_range(3))
            0:       duty = 0;
            1:       duty = 25;
            2:       duty = 50;
            default: duty = 85;
          endcase
          seg_left = $urandom_range(32, 96);
        end
        seg_left--;
        out_stall <= ($urandom_range(99) < duty);
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_t want;
    bit   bad;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        bad  = 1'b0;
        bad |= field_differs("ran_valid", want.ran_valid, out_data.ran_valid);
        bad |= field_differs("ran_slot", want.ran_slot, out_data.ran_slot);
        bad |= field_differs("finished", want.finished, out_data.finished);
        bad |= field_differs("now", want.now, out_data.now);
        bad |= field_differs("turnaround", want.turnaround, out_data.turnaround);
        bad |= field_differs("waiting", want.waiting, out_data.waiting);
        bad |= field_differs("done_count", want.done_count, out_data.done_count);
        if (bad) fail_count++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      p_arrival[i]    = '0;
      p_burst[i]      = '0;
      p_remaining[i]  = '0;
      p_turnaround[i] = '0;
      p_waiting[i]    = '0;
    end
    p_now    = '0;
    p_done   = '0;
    p_active = ACTIVE_COUNT_RST;
    p_limit  = TIME_LIMIT_RST;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_config_extremes();
    test_output_backpressure();
    test_random_traffic();

    for (int k = 0; k < DRAIN_LIMIT && pending_reports.size() != 0; k++) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_reports.size());
      fail_count++;
    end
    $display("Ran %0d transactions and %0d register writes: %0d ticks ran a slot,",
             item_count, cfg_count, ran_count);
    $display("%0d jobs completed, %0d ticks held back by the time limit.",
             finish_count, limit_skips);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/srtf_pkg.sv
rtl/core/srtf_ram.sv
rtl/core/srtf_useq.sv
rtl/core/srtf_dpath.sv
rtl/core/srtf_process_scheduler.sv
tb/sv/tb_srtf_process_scheduler.sv
